/* src/jls_pkg.sv */
// Shared types and constants for the Jacobi linear solver.
package jls_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 5;
  localparam int unsigned SwpW  = 10;

  // Largest system; the 4-bit row and component index ports are sized for it.
  localparam int unsigned MaxUnknowns = 16;

  localparam logic [CntW-1:0] UnknownReset = 5'd3;
  localparam logic [SwpW-1:0] SweepReset   = 10'd49;

  typedef enum logic [0:0] {
    CFG_UNKNOWNS = 1'b0,
    CFG_SWEEPS   = 1'b1
  } cfg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;      // store the accepted element
    logic       clr_vec;   // zero the vector, clear pivot flag
    logic       row_start; // start a new row: acc <- b[i]
    logic       mac_issue; // read A[i][j], x[j]
    logic       mac_acc;   // accumulate product of previous issue
    logic       div_start; // start divide with acc
    logic       commit;    // copy next vector into current vector
    logic       emit_rd;   // read x[i] for output
  } jls_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } jls_sts_t;

endpackage

/* src/jls_ram.sv */
// Generic single-port-write, registered-read RAM.
module jls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/jls_div.sv */
// Restoring signed divider for (t << F) / d, truncating, saturated to 32 bits.
module jls_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [jls_pkg::DataW-1:0]  num,
  input  logic signed [jls_pkg::DataW-1:0]  den,
  output logic                              busy,
  output logic                              done,
  output logic signed [jls_pkg::DataW-1:0]  quo,
  output logic                              zero_den
);
  import jls_pkg::*;

  localparam int unsigned NW = DataW + FRACTION_BITS;
  localparam int unsigned SW = $clog2(NW + 1);

  logic [NW-1:0]   n_r, n_nxt;
  logic [DataW:0]  rem_r, rem_nxt;
  logic [DataW-1:0] d_r, d_nxt;
  logic            neg_r, neg_nxt;
  logic            zd_r, zd_nxt;
  logic signed [DataW-1:0] t_r, t_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DataW:0]  trial;
  logic [DataW:0]  shifted;
  logic [NW:0]     mag;
  logic [DataW-1:0] an, ad;

  assign an = num[DataW-1] ? DataW'(-num) : DataW'(num);
  assign ad = den[DataW-1] ? DataW'(-den) : DataW'(den);
  assign shifted = {rem_r[DataW-1:0], n_r[NW-1]};
  assign trial = shifted - {1'b0, d_r};

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r; zd_nxt = zd_r;
    t_nxt = t_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      n_nxt    = {an, {FRACTION_BITS{1'b0}}};
      rem_nxt  = '0;
      d_nxt    = ad;
      neg_nxt  = num[DataW-1] ^ den[DataW-1];
      zd_nxt   = (den == '0);
      t_nxt    = num;
      cnt_nxt  = SW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[DataW]) begin
        rem_nxt = shifted;
        n_nxt   = {n_r[NW-2:0], 1'b0};
      end else begin
        rem_nxt = trial;
        n_nxt   = {n_r[NW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; zd_r <= zd_nxt; t_r <= t_nxt;
  end

  // Quotient magnitude sits in n_r once finished.
  always_comb begin
    mag = {1'b0, n_r};
    if (zd_r) begin
      if (t_r > 0)      quo = {1'b0, {(DataW-1){1'b1}}};
      else if (t_r < 0) quo = {1'b1, {(DataW-1){1'b0}}};
      else              quo = '0;
    end else if (neg_r) begin
      if (mag > (NW+1)'({1'b1, {(DataW-1){1'b0}}})) quo = {1'b1, {(DataW-1){1'b0}}};
      else quo = DataW'(-mag);
    end else begin
      if (mag > (NW+1)'({(DataW-1){1'b1}})) quo = {1'b0, {(DataW-1){1'b1}}};
      else quo = DataW'(mag);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign zero_den = zd_r;
endmodule

/* src/jls_datapath.sv */
// Datapath: matrix stores, vectors, multiply-accumulate and divide.
module jls_datapath #(
  parameter int unsigned MAX_UNKNOWNS  = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  jls_pkg::jls_cmd_t                         cmd,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0]           ld_row,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0]           ld_col,
  input  logic                                      ld_rhs,
  input  logic signed [jls_pkg::DataW-1:0]          ld_val,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0]           row_i,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0]           col_j,
  input  logic                                      skip_j,
  output jls_pkg::jls_sts_t                         sts,
  output logic signed [jls_pkg::DataW-1:0]          vec_out,
  output logic                                      pivot_flag
);
  import jls_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_UNKNOWNS);
  localparam int unsigned AW  = 2 * IW;
  // b plus up to MAX_UNKNOWNS shifted full products, kept exact
  localparam int unsigned ACW = 2 * DataW - FRACTION_BITS + IW + 2;

  localparam logic signed [ACW-1:0] SatHi =
    $signed({{(ACW-DataW+1){1'b0}}, {(DataW-1){1'b1}}});
  localparam logic signed [ACW-1:0] SatLo =
    $signed({{(ACW-DataW+1){1'b1}}, {(DataW-1){1'b0}}});

  logic signed [DataW-1:0] a_rd, b_rd;
  logic signed [DataW-1:0] cur_r [MAX_UNKNOWNS];
  logic signed [DataW-1:0] nxt_r [MAX_UNKNOWNS];
  logic signed [DataW-1:0] x_rd_r, vo_r;
  logic                    skip_r, skip2_r;
  logic signed [2*DataW-1:0] prod_r;
  logic signed [ACW-1:0]   acc_r, acc_nxt;
  logic                    pf_r;
  logic signed [DataW-1:0] t_sat, diag_r, quo;
  logic                    div_zd;
  logic [AW-1:0]           a_raddr;

  assign a_raddr = {row_i, col_j};

  jls_ram #(.WIDTH(DataW), .DEPTH(MAX_UNKNOWNS*MAX_UNKNOWNS)) u_a (
    .clk, .we(cmd.load && !ld_rhs), .waddr({ld_row, ld_col}), .wdata(ld_val),
    .raddr(a_raddr), .rdata(a_rd));
  jls_ram #(.WIDTH(DataW), .DEPTH(MAX_UNKNOWNS)) u_b (
    .clk, .we(cmd.load && ld_rhs), .waddr(ld_row), .wdata(ld_val),
    .raddr(row_i), .rdata(b_rd));

  // Stage 1 registers x[j] alongside RAM read; stage 2 multiplies.
  always_ff @(posedge clk) begin
    x_rd_r  <= cur_r[col_j];
    skip_r  <= skip_j;
    skip2_r <= skip_r;
    prod_r  <= a_rd * x_rd_r;
    if (skip_r) diag_r <= a_rd;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.row_start) acc_nxt = ACW'(b_rd);
    else if (cmd.mac_acc && !skip2_r) acc_nxt = acc_r - ACW'(prod_r >>> FRACTION_BITS);
  end

  always_ff @(posedge clk) acc_r <= acc_nxt;

  always_comb begin
    if (acc_r > SatHi)      t_sat = {1'b0, {(DataW-1){1'b1}}};
    else if (acc_r < SatLo) t_sat = {1'b1, {(DataW-1){1'b0}}};
    else                    t_sat = acc_r[DataW-1:0];
  end

  jls_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk, .rst_n, .start(cmd.div_start), .num(t_sat), .den(diag_r),
    .busy(sts.div_busy), .done(sts.div_done), .quo, .zero_den(div_zd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r <= 1'b0;
      for (int k = 0; k < MAX_UNKNOWNS; k++) cur_r[k] <= '0;
    end else begin
      if (cmd.clr_vec) begin
        pf_r <= 1'b0;
        for (int k = 0; k < MAX_UNKNOWNS; k++) cur_r[k] <= '0;
      end else if (cmd.commit) begin
        // the last row's quotient lands in the same cycle
        for (int k = 0; k < MAX_UNKNOWNS; k++)
          cur_r[k] <= (IW'(k) == row_i) ? quo : nxt_r[k];
      end
      if (sts.div_done && div_zd) pf_r <= 1'b1;
    end
    if (sts.div_done) nxt_r[row_i] <= quo;
    if (cmd.emit_rd) vo_r <= cur_r[row_i];
  end

  assign vec_out = vo_r;
  assign pivot_flag = pf_r;
endmodule

/* src/jls_ctrl.sv */
// Controller: load, sweep sequencing and result emission.
module jls_ctrl #(
  parameter int unsigned MAX_UNKNOWNS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                final_in,
  input  logic [jls_pkg::CntW-1:0]            n_act,
  input  logic [jls_pkg::SwpW-1:0]            sweeps,
  input  jls_pkg::jls_sts_t                   sts,
  output jls_pkg::jls_cmd_t                   cmd,
  output logic [$clog2(MAX_UNKNOWNS)-1:0]     row_i,
  output logic [$clog2(MAX_UNKNOWNS)-1:0]     col_j,
  output logic                                skip_j,
  output logic                                busy,
  output logic                                out_v,
  output logic [$clog2(MAX_UNKNOWNS)-1:0]     out_idx,
  output logic                                out_last
);
  import jls_pkg::*;

  localparam int unsigned IW = $clog2(MAX_UNKNOWNS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_ROW  = 7'b0000010, S_MAC  = 7'b0000100,
    S_DRN  = 7'b0001000, S_DIV  = 7'b0010000, S_EMRD = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [SwpW-1:0] sw_r, sw_nxt;
  logic [1:0] drn_r, drn_nxt;
  logic [IW-1:0] nm1;
  logic jlast;
  logic iss1_r, iss2_r;

  assign nm1 = IW'(n_act - 1'b1);
  assign jlast = (j_r == nm1);

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; sw_nxt = sw_r; drn_nxt = drn_r;
    cmd = '0;
    out_v = 1'b0;
    cmd.load = accept;
    // b[i] is read by the first issue cycle; each product is registered in prod_r after the RAM read and x[j] registers
    cmd.row_start = iss1_r && !iss2_r;
    cmd.mac_acc = iss2_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept && final_in) begin
          cmd.clr_vec = 1'b1;
          i_nxt = '0; sw_nxt = '0;
          st_nxt = (sweeps == '0) ? S_EMRD : S_ROW;
        end
      end
      S_ROW: begin
        j_nxt = '0;
        st_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (jlast) begin
          drn_nxt = 2'd0;
          st_nxt = S_DRN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRN: begin
        drn_nxt = drn_r + 1'b1;
        if (drn_r == 2'd2) begin
          cmd.div_start = 1'b1;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (i_r == nm1) begin
            i_nxt = '0;
            cmd.commit = 1'b1;
            sw_nxt = sw_r + 1'b1;
            st_nxt = (sw_r + 1'b1 == sweeps) ? S_EMRD : S_ROW;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_ROW;
          end
        end
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_v = 1'b1;
        if (i_r == nm1) begin
          st_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = S_EMRD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; sw_r <= '0; drn_r <= '0;
      iss1_r <= 1'b0; iss2_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; sw_r <= sw_nxt; drn_r <= drn_nxt;
      iss1_r <= cmd.mac_issue; iss2_r <= iss1_r;
    end
  end

  assign row_i = i_r;
  assign col_j = j_r;
  assign skip_j = (j_r == i_r);
  assign busy = (st_r != S_IDLE);
  assign out_idx = i_r;
  assign out_last = (i_r == nm1);
endmodule

/* src/jacobi_linear_solver.sv */
// Jacobi linear solver top level.
// Loads [A|b] one element per cycle while busy is low. After a final element,
// runs sweep_count sweeps; each row is read, multiplied and accumulated
// (one product per cycle through a registered RAM read and multiplier)
// and then divided in the shift-subtract divider. Results then appear on
// out_valid; they cannot be held off. busy stays high until the last
// component is out, and configuration writes are held off while busy.
module jacobi_linear_solver #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   in_row_index,
  input  logic [4:0]                   in_column_index,
  input  logic signed [31:0]           in_element_value,
  input  logic                         in_final_element,
  output logic                         out_valid,
  output logic [3:0]                   out_component_index,
  output logic signed [31:0]           out_component_value,
  output logic                         out_zero_pivot,
  output logic                         out_last_component,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [9:0]                   cfg_data
);
  import jls_pkg::*;

  localparam int unsigned IW = $clog2(MaxUnknowns);

  logic [CntW-1:0] unk_r;
  logic [SwpW-1:0] swp_r;
  logic [CntW-1:0] n_act;
  logic accept, ld_ok, ld_rhs;
  jls_cmd_t cmd, cmd_dp;
  jls_sts_t sts;
  logic [IW-1:0] row_i, col_j, o_idx;
  logic skip_j, o_v, o_last, pf;
  logic signed [DataW-1:0] vo;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unk_r <= UnknownReset;
      swp_r <= SweepReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_UNKNOWNS: unk_r <= cfg_data[CntW-1:0];
        CFG_SWEEPS:   swp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (unk_r == '0) n_act = CntW'(1);
    else if (32'(unk_r) > MaxUnknowns) n_act = CntW'(MaxUnknowns);
    else n_act = unk_r;
  end

  assign accept = start && !busy;
  assign ld_rhs = (in_column_index == n_act);
  assign ld_ok = accept && (32'(in_row_index) < MaxUnknowns) &&
                 (in_column_index <= n_act);

  jls_ctrl #(.MAX_UNKNOWNS(MaxUnknowns)) u_ctrl (
    .clk, .rst_n, .accept, .final_in(in_final_element), .n_act, .sweeps(swp_r),
    .sts, .cmd, .row_i, .col_j, .skip_j, .busy, .out_v(o_v), .out_idx(o_idx),
    .out_last(o_last));

  // Only elements that land in a store are written.
  always_comb begin
    cmd_dp = cmd;
    cmd_dp.load = ld_ok;
  end

  jls_datapath #(.MAX_UNKNOWNS(MaxUnknowns), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk, .rst_n, .cmd(cmd_dp), .ld_row(IW'(in_row_index)),
    .ld_col(IW'(in_column_index)), .ld_rhs, .ld_val(in_element_value),
    .row_i, .col_j, .skip_j, .sts, .vec_out(vo), .pivot_flag(pf));

  assign out_valid = o_v;
  assign out_component_index = 4'(o_idx);
  assign out_component_value = vo;
  assign out_zero_pivot = pf;
  assign out_last_component = o_v && o_last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_component) |=> !busy) else $error("busy after last");
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sts.div_busy) else $error("emit during divide");
endmodule
